>>> hdl/keyed_latency_histogram_macros.svh
// assertion macros shared by the keyed latency histogram rtl
`ifndef KEYED_LATENCY_HISTOGRAM_MACROS_SVH
`define KEYED_LATENCY_HISTOGRAM_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KLH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KLH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/klh_pkg.sv
// shared constants, types and bucket selection for the keyed latency histogram
`default_nettype none

package klh_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int BUCKET_COUNT  = 10;
  localparam int BKT_W         = 4;
  localparam int LIMIT_COUNT   = 9;

  localparam logic [31:0] LIMITS [LIMIT_COUNT] = '{
    32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd5000000, 32'd10000000, 32'd30000000
  };

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] TOT_MAX = 48'hFFFF_FFFF_FFFF;

  // action codes
  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_ERASE  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;

  typedef struct packed {
    logic             start;
    logic             clr_all;
    logic             set_en;
    logic             clr_en;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [BKT_W-1:0] bkt;
    logic             zero_en;
    logic             upd_en;
    logic             fresh;
  } stat_cmd_t;

  typedef struct packed {
    logic [31:0] count;
    logic [47:0] total;
    logic [31:0] bkt;
  } stat_rd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count;
    logic [47:0] total;
    logic [31:0] bkt;
  } res_t;

  // first limit the duration stays below, else the last bucket
  function automatic logic [BKT_W-1:0] pick_bucket(input logic [31:0] d);
    logic [BKT_W-1:0] b;
    b = BKT_W'(LIMIT_COUNT);
    for (int s = LIMIT_COUNT - 1; s >= 0; s--) begin
      if (d < LIMITS[s]) begin
        b = BKT_W'(s);
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/klh_key_scan.sv
// key memory, entry valid bits and the one-entry-per-cycle key compare scan
`default_nettype none

module klh_key_scan (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire klh_pkg::scan_ctl_t  ctl,
  input  wire logic [31:0]         hash,
  output klh_pkg::scan_res_t       res
);

  localparam logic [klh_pkg::IDX_W-1:0] LAST_IDX =
    klh_pkg::IDX_W'(klh_pkg::TABLE_ENTRIES - 1);

  logic [31:0]                 key_mem [klh_pkg::TABLE_ENTRIES];
  logic [klh_pkg::TABLE_ENTRIES-1:0] valid_r;
  logic                        busy_r;
  logic                        pv_r;
  logic [klh_pkg::IDX_W-1:0]   idx_r;
  logic [klh_pkg::IDX_W-1:0]   pidx_r;
  logic [31:0]                 key_rd_r;
  logic                        free_ok_r;
  logic [klh_pkg::IDX_W-1:0]   free_idx_r;

  logic vld_cur;
  logic match;
  logic done;

  assign vld_cur = valid_r[pidx_r];
  assign match   = pv_r && vld_cur && (key_rd_r == hash);
  assign done    = match || (pv_r && (pidx_r == LAST_IDX));

  assign res.done     = done;
  assign res.hit      = match;
  assign res.hit_idx  = pidx_r;
  assign res.free_ok  = free_ok_r || (pv_r && !vld_cur);
  assign res.free_idx = free_ok_r ? free_idx_r : pidx_r;

  // key store, read one entry per scan cycle
  always_ff @(posedge clk) begin
    if (busy_r) begin
      key_rd_r <= key_mem[idx_r];
    end
    if (ctl.set_en) begin
      key_mem[ctl.idx] <= hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        valid_r <= '0;
      end else if (ctl.set_en) begin
        valid_r[ctl.idx] <= 1'b1;
      end else if (ctl.clr_en) begin
        valid_r[ctl.idx] <= 1'b0;
      end

      if (ctl.start) begin
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
      end else if (done) begin
        busy_r <= 1'b0;
        pv_r   <= 1'b0;
      end else begin
        pv_r <= busy_r;
        if (busy_r && (idx_r == LAST_IDX)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      idx_r     <= '0;
      free_ok_r <= 1'b0;
    end else begin
      if (busy_r) begin
        pidx_r <= idx_r;
        idx_r  <= idx_r + 1'b1;
      end
      if (pv_r && !vld_cur && !free_ok_r) begin
        free_ok_r  <= 1'b1;
        free_idx_r <= pidx_r;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/klh_stats.sv
// per-entry count, total and bucket memories with the saturating update
`default_nettype none

module klh_stats (
  input  wire logic               clk,
  input  wire klh_pkg::stat_cmd_t cmd,
  input  wire logic [31:0]        dur,
  output klh_pkg::stat_rd_t       rd
);

  localparam int BKT_AW    = klh_pkg::IDX_W + klh_pkg::BKT_W;
  localparam int BKT_DEPTH = 1 << BKT_AW;

  logic [31:0] count_mem [klh_pkg::TABLE_ENTRIES];
  logic [47:0] total_mem [klh_pkg::TABLE_ENTRIES];
  logic [31:0] bkt_mem   [BKT_DEPTH];

  logic [31:0] count_rd_r;
  logic [47:0] total_rd_r;
  logic [31:0] bkt_rd_r;

  logic [BKT_AW-1:0] bkt_addr;
  logic [31:0]       cnt_base;
  logic [47:0]       tot_base;
  logic [48:0]       tot_sum;
  logic [31:0]       cnt_nxt;
  logic [47:0]       tot_nxt;
  logic [31:0]       bkt_nxt;

  assign bkt_addr = {cmd.idx, cmd.bkt};

  // a freshly allocated entry starts from zero
  assign cnt_base = cmd.fresh ? 32'd0 : count_rd_r;
  assign tot_base = cmd.fresh ? 48'd0 : total_rd_r;
  assign tot_sum  = {1'b0, tot_base} + {17'd0, dur};
  assign cnt_nxt  = (cnt_base == klh_pkg::CNT_MAX) ? cnt_base : cnt_base + 32'd1;
  assign tot_nxt  = tot_sum[48] ? klh_pkg::TOT_MAX : tot_sum[47:0];
  assign bkt_nxt  = (bkt_rd_r == klh_pkg::CNT_MAX) ? bkt_rd_r : bkt_rd_r + 32'd1;

  assign rd.count = count_rd_r;
  assign rd.total = total_rd_r;
  assign rd.bkt   = bkt_rd_r;

  always_ff @(posedge clk) begin
    count_rd_r <= count_mem[cmd.idx];
    total_rd_r <= total_mem[cmd.idx];
    bkt_rd_r   <= bkt_mem[bkt_addr];
    if (cmd.upd_en) begin
      count_mem[cmd.idx] <= cnt_nxt;
      total_mem[cmd.idx] <= tot_nxt;
    end
    if (cmd.zero_en) begin
      bkt_mem[bkt_addr] <= 32'd0;
    end else if (cmd.upd_en) begin
      bkt_mem[bkt_addr] <= bkt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/keyed_latency_histogram.sv
// top level of the keyed latency histogram: sequencer, result register, ports
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_stall   in_action, in_key_hash, in_duration,
//                                       in_bucket_select
//   out      out  out_valid / out_stall out_status, out_event_count,
//                                       out_total_time, out_bucket_count
//
// one item at a time; in_stall is high from the accepting edge until the
// result is loaded into the output register
// the key scan compares one table entry per cycle: a hit ends the scan at that
// entry, a miss ends it after the last entry; afterwards a record hit reads and
// updates, an allocating record first zeroes its ten buckets, a query hit reads
// back, erase and misses go straight to the result, and so does clear
// synchronous active-low reset empties the table at once, no clearing pass
// a result held by out_stall does not block the next input beat
`default_nettype none
`include "keyed_latency_histogram_macros.svh"

module keyed_latency_histogram (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_key_hash,
  input  wire logic [31:0] in_duration,
  input  wire logic [3:0]  in_bucket_select,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_event_count,
  output logic [47:0]      out_total_time,
  output logic [31:0]      out_bucket_count
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_RD1   = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_RDS   = 3'd5;
  localparam logic [2:0] ST_CAP   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam logic [klh_pkg::BKT_W-1:0] LAST_BKT =
    klh_pkg::BKT_W'(klh_pkg::BUCKET_COUNT - 1);
  localparam logic [klh_pkg::BKT_W-1:0] NUM_BKT =
    klh_pkg::BKT_W'(klh_pkg::BUCKET_COUNT);

  logic [2:0] state_r, state_nxt;

  // the item being worked on
  logic [1:0]                act_r, act_nxt;
  logic [31:0]               hash_r, hash_nxt;
  logic [31:0]               dur_r, dur_nxt;
  logic [3:0]                sel_r, sel_nxt;
  logic [klh_pkg::BKT_W-1:0] pick_r, pick_nxt;

  // entry under update and sweep position
  logic [klh_pkg::IDX_W-1:0] ent_r, ent_nxt;
  logic                      fresh_r, fresh_nxt;
  logic [klh_pkg::BKT_W-1:0] zc_r, zc_nxt;

  // result being built, and the output register
  klh_pkg::res_t res_r, res_nxt;
  klh_pkg::res_t out_res_r, out_res_nxt;
  logic          out_valid_r, out_valid_nxt;

  klh_pkg::scan_ctl_t scan_ctl;
  klh_pkg::scan_res_t scan_res;
  klh_pkg::stat_cmd_t stat_cmd;
  klh_pkg::stat_rd_t  stat_rd;

  logic in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_event_count  = out_res_r.count;
  assign out_total_time   = out_res_r.total;
  assign out_bucket_count = out_res_r.bkt;

  klh_key_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .hash  (hash_r),
    .res   (scan_res)
  );

  klh_stats u_stats (
    .clk (clk),
    .cmd (stat_cmd),
    .dur (dur_r),
    .rd  (stat_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    hash_nxt      = hash_r;
    dur_nxt       = dur_r;
    sel_nxt       = sel_r;
    pick_nxt      = pick_r;
    ent_nxt       = ent_r;
    fresh_nxt     = fresh_r;
    zc_nxt        = zc_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    // the held result leaves when the far side takes it
    out_valid_nxt = out_valid_r && out_stall;

    scan_ctl       = '0;
    stat_cmd.idx   = ent_r;
    stat_cmd.bkt   = pick_r;
    stat_cmd.zero_en = 1'b0;
    stat_cmd.upd_en  = 1'b0;
    stat_cmd.fresh   = fresh_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_action;
          hash_nxt = in_key_hash;
          dur_nxt  = in_duration;
          sel_nxt  = in_bucket_select;
          pick_nxt = klh_pkg::pick_bucket(in_duration);
          res_nxt  = '0;
          if (in_action == klh_pkg::ACT_CLEAR) begin
            scan_ctl.clr_all = 1'b1;
            state_nxt        = ST_DONE;
          end else begin
            scan_ctl.start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_DONE;
          case (act_r)
            klh_pkg::ACT_RECORD: begin
              if (scan_res.hit) begin
                ent_nxt   = scan_res.hit_idx;
                fresh_nxt = 1'b0;
                state_nxt = ST_RD1;
              end else if (scan_res.free_ok) begin
                // claim the lowest free entry, then zero its buckets
                ent_nxt         = scan_res.free_idx;
                fresh_nxt       = 1'b1;
                zc_nxt          = '0;
                scan_ctl.set_en = 1'b1;
                scan_ctl.idx    = scan_res.free_idx;
                state_nxt       = ST_SWEEP;
              end else begin
                res_nxt.status = klh_pkg::STS_FULL;
              end
            end
            klh_pkg::ACT_QUERY: begin
              if (scan_res.hit) begin
                ent_nxt   = scan_res.hit_idx;
                state_nxt = ST_RDS;
              end else begin
                res_nxt.status = klh_pkg::STS_NOT_FOUND;
              end
            end
            klh_pkg::ACT_ERASE: begin
              if (scan_res.hit) begin
                scan_ctl.clr_en = 1'b1;
                scan_ctl.idx    = scan_res.hit_idx;
              end else begin
                res_nxt.status = klh_pkg::STS_NOT_FOUND;
              end
            end
            default: begin
              res_nxt.status = klh_pkg::STS_OK;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        stat_cmd.zero_en = 1'b1;
        stat_cmd.bkt     = zc_r;
        zc_nxt           = zc_r + 1'b1;
        if (zc_r == LAST_BKT) begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        // fetch count, total and the chosen bucket
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        stat_cmd.upd_en = 1'b1;
        state_nxt       = ST_RDS;
      end
      ST_RDS: begin
        // read back with the requested bucket
        stat_cmd.bkt = sel_r;
        state_nxt    = ST_CAP;
      end
      ST_CAP: begin
        res_nxt.status = klh_pkg::STS_OK;
        res_nxt.count  = stat_rd.count;
        res_nxt.total  = stat_rd.total;
        res_nxt.bkt    = (sel_r < NUM_BKT) ? stat_rd.bkt : 32'd0;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    hash_r    <= hash_nxt;
    dur_r     <= dur_nxt;
    sel_r     <= sel_nxt;
    pick_r    <= pick_nxt;
    ent_r     <= ent_nxt;
    fresh_r   <= fresh_nxt;
    zc_r      <= zc_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  `KLH_ASSERT_IMP(a_scan_done_in_scan, scan_res.done, state_r == ST_SCAN, "scan done outside scan")
  `KLH_ASSERT_NXT(a_beat_leaves_idle, in_valid && !in_stall, state_r != ST_IDLE, "beat taken but idle")
  `KLH_ASSERT_IMP(a_sweep_on_alloc, state_r == ST_SWEEP, act_r == klh_pkg::ACT_RECORD && fresh_r, "sweep without allocation")
  `KLH_ASSERT_NXT(a_done_loads_out, state_r == ST_DONE && (!out_valid_r || !out_stall), out_valid_r && state_r == ST_IDLE, "result not loaded")

endmodule

`default_nettype wire

>>> sim/keyed_latency_histogram_tb.sv
// self-checking testbench for the keyed latency histogram, with a predictor of the table
`timescale 1ns / 1ps

module keyed_latency_histogram_tb;
  import klh_pkg::*;

  localparam int RAND_ITEMS   = 1300;
  localparam int BIG_RECORDS  = 40;     // back-to-back largest-duration records on one key
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;    // covers the worst case, a miss plus allocation
  localparam int WD_LIMIT     = 4000;

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] key;
    logic [31:0] dur;
    logic [3:0]  sel;
    logic        has_exp;
    res_t        exp;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [31:0] in_key_hash;
  logic [31:0] in_duration;
  logic [3:0]  in_bucket_select;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_event_count;
  logic [47:0] out_total_time;
  logic [31:0] out_bucket_count;

  // predictor copy of the timing table
  logic        entry_live [TABLE_ENTRIES];
  logic [31:0] entry_tag  [TABLE_ENTRIES];
  logic [31:0] entry_cnt  [TABLE_ENTRIES];
  logic [47:0] entry_sum  [TABLE_ENTRIES];
  logic [31:0] entry_bins [TABLE_ENTRIES][BUCKET_COUNT];

  res_t awaited_results [$];
  res_t typed_result;
  logic typed_valid;
  res_t want;
  int   mismatches = 0;
  int   burst_left = 0;
  bit   rx_quiet = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;

  keyed_latency_histogram dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_key_hash      (in_key_hash),
    .in_duration      (in_duration),
    .in_bucket_select (in_bucket_select),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_event_count  (out_event_count),
    .out_total_time   (out_total_time),
    .out_bucket_count (out_bucket_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // applies one action to the predicted table and returns the result it gives
  function automatic res_t next_histogram_result(input logic [1:0] act, input logic [31:0] key,
                                                 input logic [31:0] dur, input logic [3:0] sel);
    res_t        r;
    int          slot;
    int          bin;
    logic        report;
    logic [48:0] sum;
    r = '0;
    report = 1'b0;
    slot = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (entry_live[i] && entry_tag[i] == key) slot = i;
    end
    case (act)
      ACT_RECORD: begin
        if (slot < 0) begin
          for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!entry_live[i]) slot = i;
          end
          if (slot >= 0) begin
            entry_live[slot] = 1'b1;
            entry_tag[slot]  = key;
            entry_cnt[slot]  = '0;
            entry_sum[slot]  = '0;
            for (int b = 0; b < BUCKET_COUNT; b++) entry_bins[slot][b] = '0;
          end
        end
        if (slot < 0) begin
          r.status = STS_FULL;
        end else begin
          bin = BUCKET_COUNT - 1;
          for (int s = 0; s < LIMIT_COUNT; s++) begin
            if (bin == BUCKET_COUNT - 1 && dur < LIMITS[s]) bin = s;
          end
          if (entry_cnt[slot] != CNT_MAX) entry_cnt[slot] = entry_cnt[slot] + 1;
          if (entry_bins[slot][bin] != CNT_MAX) entry_bins[slot][bin] = entry_bins[slot][bin] + 1;
          sum = {1'b0, entry_sum[slot]} + dur;
          entry_sum[slot] = (sum > {1'b0, TOT_MAX}) ? TOT_MAX : sum[47:0];
          report = 1'b1;
        end
      end
      ACT_QUERY: begin
        if (slot < 0) r.status = STS_NOT_FOUND;
        else report = 1'b1;
      end
      ACT_ERASE: begin
        if (slot < 0) r.status = STS_NOT_FOUND;
        else entry_live[slot] = 1'b0;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) entry_live[i] = 1'b0;
      end
    endcase
    if (report) begin
      r.status = STS_OK;
      r.count  = entry_cnt[slot];
      r.total  = entry_sum[slot];
      r.bkt    = (sel < BUCKET_COUNT) ? entry_bins[slot][sel] : '0;
    end
    return r;
  endfunction

  function automatic beat_t make_beat(input logic [1:0] act, input logic [31:0] key,
                                      input logic [31:0] dur, input logic [3:0] sel,
                                      input logic has, input logic [1:0] sts,
                                      input logic [31:0] cnt, input logic [47:0] tot,
                                      input logic [31:0] bkt);
    beat_t b;
    b.act = act;
    b.key = key;
    b.dur = dur;
    b.sel = sel;
    b.has_exp = has;
    b.exp.status = sts;
    b.exp.count = cnt;
    b.exp.total = tot;
    b.exp.bkt = bkt;
    return b;
  endfunction

  task automatic check_field(input string what, input logic [47:0] exp_v, input logic [47:0] got);
    if (got !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got);
    end
  endtask

  // offer one beat from the falling edge and hold it until accepted
  task automatic send_beat(input beat_t b);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_action        <= b.act;
    in_key_hash      <= b.key;
    in_duration      <= b.dur;
    in_bucket_select <= b.sel;
    typed_valid      <= b.has_exp;
    typed_result     <= b.exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid         <= 1'b0;
      in_action        <= 2'($urandom);
      in_key_hash      <= $urandom;
      in_duration      <= $urandom;
      in_bucket_select <= 4'($urandom);
    end
  endtask

  // bursts of random length, random gaps between them
  task automatic send_paced(input beat_t b);
    send_beat(b);
    if (burst_left == 0) begin
      pause($urandom_range(1, 15));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle;
    pause(1);
    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input side: predict on every accepted beat
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      want = next_histogram_result(in_action, in_key_hash, in_duration, in_bucket_select);
      if (typed_valid) awaited_results.push_back(typed_result);
      else awaited_results.push_back(want);
    end
  end

  // output side: compare against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, actual status %h count %h",
                 $time, out_status, out_event_count);
      end else begin
        exp_r = awaited_results.pop_front();
        check_field("status", exp_r.status, out_status);
        check_field("event_count", exp_r.count, out_event_count);
        check_field("total_time", exp_r.total, out_total_time);
        check_field("bucket_count", exp_r.bkt, out_bucket_count);
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin : receiver
    int   mode;
    int   left;
    int   tick;
    int   period;
    logic stall_nxt;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    period = 3;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 200);
          period = $urandom_range(2, 7);
        end
        left--;
        tick++;
        case (mode)
          0:       stall_nxt = 1'b0;
          1:       stall_nxt = ($urandom_range(0, 3) == 0);
          default: stall_nxt = ((tick % period) == 0);
        endcase
        if (rx_quiet) stall_nxt = 1'b0;
        out_stall <= stall_nxt;
      end
    end
  end

  // watchdog: too long without any beat on either side
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WD_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WD_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    beat_t       dir_beats [$];
    logic [31:0] key_pool [80];
    logic [31:0] base;
    logic [31:0] key;
    logic [31:0] dur;
    logic [1:0]  act;
    logic [3:0]  sel;
    int          pool_n;
    int          batch_n;
    int          pick;
    int          lim;
    int          rand_items;
    bit          hold_started;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = '0;
    in_key_hash = '0;
    in_duration = '0;
    in_bucket_select = '0;
    typed_valid = 1'b0;
    typed_result = '0;
    rand_items = 0;
    hold_started = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      entry_live[i] = 1'b0;
      entry_tag[i] = '0;
      entry_cnt[i] = '0;
      entry_sum[i] = '0;
      for (int b = 0; b < BUCKET_COUNT; b++) entry_bins[i][b] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, bucket limits, out-of-range select, erase and reuse
    dir_beats.push_back(make_beat(ACT_QUERY, 32'hA5A5_5A5A, 0, 0, 1, STS_NOT_FOUND, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_ERASE, 32'hA5A5_5A5A, 0, 0, 1, STS_NOT_FOUND, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_CLEAR, 32'h0, 0, 0, 1, STS_OK, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'h0, 0, 0, 1, STS_OK, 1, 0, 1));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'h0, 9, 0, 1, STS_OK, 2, 9, 2));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'h0, 10, 1, 1, STS_OK, 3, 19, 1));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 99, 1, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 100, 2, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 9999, 3, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 10000, 4, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 1000000, 6, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 4999999, 6, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 5000000, 7, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 10000000, 8, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 30000000, 9, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_QUERY, 32'hFFFF_FFFF, 0, 15, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_QUERY, 32'hFFFF_FFFF, 0, 10, 0, 0, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_ERASE, 32'h0, 0, 0, 1, STS_OK, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_QUERY, 32'h0, 0, 0, 1, STS_NOT_FOUND, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_RECORD, 32'h0, 5, 0, 1, STS_OK, 1, 5, 1));
    dir_beats.push_back(make_beat(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15, 1, STS_OK, 0, 0, 0));
    dir_beats.push_back(make_beat(ACT_QUERY, 32'hFFFF_FFFF, 0, 9, 1, STS_NOT_FOUND, 0, 0, 0));
    foreach (dir_beats[i]) send_paced(dir_beats[i]);
    wait_idle();

    // fill the table, overflow it, then free one entry and reuse it
    base = $urandom;
    send_paced(make_beat(ACT_CLEAR, $urandom, $urandom, 4'($urandom), 0, 0, 0, 0, 0));
    for (int i = 0; i < TABLE_ENTRIES + 6; i++) begin
      send_paced(make_beat(ACT_RECORD, base ^ i, $urandom_range(0, 200000),
                           4'($urandom_range(0, 15)), 0, 0, 0, 0, 0));
    end
    send_paced(make_beat(ACT_QUERY, base ^ 3, 0, 4'($urandom_range(0, 9)), 0, 0, 0, 0, 0));
    send_paced(make_beat(ACT_RECORD, base ^ 7, $urandom, 4'($urandom_range(0, 9)),
                         0, 0, 0, 0, 0));
    send_paced(make_beat(ACT_ERASE, base ^ 5, 0, 0, 0, 0, 0, 0, 0));
    send_paced(make_beat(ACT_RECORD, base ^ 100, $urandom, 4'($urandom_range(0, 9)),
                         0, 0, 0, 0, 0));
    send_paced(make_beat(ACT_RECORD, base ^ 101, $urandom, 4'($urandom_range(0, 9)),
                         0, 0, 0, 0, 0));
    send_paced(make_beat(ACT_QUERY, base ^ 100, 0, 4'($urandom_range(0, 15)), 0, 0, 0, 0, 0));
    wait_idle();

    // random batches over small key pools, now and then a pool near or above the table size
    while (rand_items < RAND_ITEMS) begin
      pool_n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 72) : $urandom_range(2, 24);
      for (int i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 19))
          0:       key_pool[i] = 32'h0;
          1:       key_pool[i] = 32'hFFFF_FFFF;
          default: key_pool[i] = $urandom;
        endcase
      end
      batch_n = $urandom_range(30, 120);
      for (int j = 0; j < batch_n; j++) begin
        pick = $urandom_range(0, 99);
        key = key_pool[$urandom_range(0, pool_n - 1)];
        if (pick < 55) act = ACT_RECORD;
        else if (pick < 78) act = ACT_QUERY;
        else if (pick < 90) act = ACT_ERASE;
        else if (pick < 92) act = ACT_CLEAR;
        else begin
          act = 2'($urandom);
          key = $urandom;
        end
        lim = $urandom_range(0, LIMIT_COUNT - 1);
        case ($urandom_range(0, 3))
          0:       dur = $urandom;
          1:       dur = LIMITS[lim] - $urandom_range(0, 1);
          2:       dur = $urandom_range(0, 20000);
          default: dur = $urandom >> $urandom_range(0, 31);
        endcase
        sel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
        send_paced(make_beat(act, key, dur, sel, 0, 0, 0, 0, 0));
        rand_items++;
        // long receiver hold-off while beats keep coming
        if (!hold_started && rand_items >= 500) begin
          hold_started = 1'b1;
          hold_req = 1'b1;
          burst_left = 60;
        end
      end
      if ($urandom_range(0, 2) == 0) wait_idle();
    end
    wait (hold_done);
    wait_idle();

    // one key hit back to back with the largest duration
    rx_quiet = 1'b1;
    key = $urandom;
    send_beat(make_beat(ACT_CLEAR, $urandom, $urandom, 4'($urandom), 0, 0, 0, 0, 0));
    repeat (BIG_RECORDS) begin
      send_beat(make_beat(ACT_RECORD, key, 32'hFFFF_FFFF, 4'($urandom_range(0, 15)),
                          0, 0, 0, 0, 0));
    end
    send_beat(make_beat(ACT_RECORD, key, 32'h0, 0, 0, 0, 0, 0, 0));
    send_beat(make_beat(ACT_QUERY, key, 0, BUCKET_COUNT - 1, 0, 0, 0, 0, 0));
    rx_quiet = 1'b0;
    wait_idle();

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
